// File: sv/stl_pkg.sv
// Package for the script token lexer: token kinds, lexer modes, the result record
// and the keyword table. It has no dependencies.
package stl_pkg;

    localparam int NKW = 13;

    // Token kinds.
    localparam logic [5:0] K_EOS           = 6'd0;
    localparam logic [5:0] K_PLUS          = 6'd1;
    localparam logic [5:0] K_PLUS_EQUAL    = 6'd2;
    localparam logic [5:0] K_MINUS         = 6'd3;
    localparam logic [5:0] K_MINUS_EQUAL   = 6'd4;
    localparam logic [5:0] K_ARROW         = 6'd5;
    localparam logic [5:0] K_MUL           = 6'd6;
    localparam logic [5:0] K_MUL_EQUAL     = 6'd7;
    localparam logic [5:0] K_DIV           = 6'd8;
    localparam logic [5:0] K_DIV_EQUAL     = 6'd9;
    localparam logic [5:0] K_NOT           = 6'd10;
    localparam logic [5:0] K_NOT_EQUAL     = 6'd11;
    localparam logic [5:0] K_AND           = 6'd12;
    localparam logic [5:0] K_OR            = 6'd13;
    localparam logic [5:0] K_OPEN_PAREN    = 6'd14;
    localparam logic [5:0] K_CLOSE_PAREN   = 6'd15;
    localparam logic [5:0] K_OPEN_BRACE    = 6'd16;
    localparam logic [5:0] K_CLOSE_BRACE   = 6'd17;
    localparam logic [5:0] K_EQUAL         = 6'd18;
    localparam logic [5:0] K_DOUBLE_EQUAL  = 6'd19;
    localparam logic [5:0] K_SEMICOLON     = 6'd20;
    localparam logic [5:0] K_COLON         = 6'd21;
    localparam logic [5:0] K_COMMA         = 6'd22;
    localparam logic [5:0] K_LESS          = 6'd23;
    localparam logic [5:0] K_LESS_EQUAL    = 6'd24;
    localparam logic [5:0] K_GREATER       = 6'd25;
    localparam logic [5:0] K_GREATER_EQUAL = 6'd26;
    localparam logic [5:0] K_MODULO        = 6'd27;
    localparam logic [5:0] K_MODULO_EQUAL  = 6'd28;
    localparam logic [5:0] K_INT           = 6'd29;
    localparam logic [5:0] K_FLOAT         = 6'd30;
    localparam logic [5:0] K_STR           = 6'd31;
    localparam logic [5:0] K_BOOL          = 6'd32;
    localparam logic [5:0] K_IDENT         = 6'd33;

    // Error codes.
    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_BAD_CHAR = 2'd1;
    localparam logic [1:0] E_LONE_OP  = 2'd2;
    localparam logic [1:0] E_OPEN_STR = 2'd3;

    localparam logic [62:0] INT_SAT = {63{1'b1}};

    typedef enum logic [2:0] {
        M_IDLE, M_OP, M_COMMENT, M_NUMBER, M_IDENT, M_STRING, M_DROP
    } t_mode;

    // One result item.
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] start;
        logic [15:0] length;
        logic [62:0] ival;
        logic        bval;
        logic [1:0]  err;
        logic        last;
    } t_tok;

    // Keyword table; the text is right aligned, first character highest.
    localparam logic [63:0] KW_TEXT [NKW] = '{
        64'("if"), 64'("else"), 64'("while"), 64'("fn"), 64'("let"), 64'("const"),
        64'("break"), 64'("continue"), 64'("return"), 64'("true"), 64'("false"),
        64'("null"), 64'("for")
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd2, 4'd4, 4'd5, 4'd2, 4'd3, 4'd5, 4'd5, 4'd8, 4'd6, 4'd4, 4'd5, 4'd4, 4'd3
    };
    localparam logic [5:0] KW_KIND [NKW] = '{
        6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42,
        K_BOOL, K_BOOL, 6'd43, 6'd44
    };
    localparam int KW_TRUE = 9;

    // Character i of keyword k, or zero past its end.
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
        logic [3:0] sh;
        begin
            sh = KW_LEN[k] - 4'd1 - i;
            if (i >= KW_LEN[k]) begin
                kw_char = 8'd0;
            end else begin
                kw_char = KW_TEXT[k][{sh[2:0], 3'b000} +: 8];
            end
        end
    endfunction

endpackage

// File: sv/script_token_lexer.sv
// Top level of the script token lexer: input register, one-pass lexer step and
// a three-entry result queue. Depends on stl_pkg.
//
// Usage: source bytes enter on the input channel (i_valid / o_ready, payload
// i_ch and i_end_of_input); tokens leave on the output channel (o_valid /
// i_ready) with kind, line, start, length, integer value, boolean value,
// error code and a flag marking the last token caused by a byte.
// A byte is registered on its transfer and lexed once the result queue is
// empty or showing its last token; the byte's tokens are registered into
// the queue and shown from there.
// The block takes one byte per cycle while each byte causes at most one
// token and the receiver is ready; a byte that causes two or three tokens
// holds the lexer step until all but its last token have transferred, since
// the result queue drains one token a cycle while the receiver is ready.
// A zero byte or the end flag finishes the pending token, emits the end of
// stream token if no error ended the text, and starts a fresh text at offset
// 0, line 1. After an error token, bytes are dropped up to the end of the text.
// Reset (synchronous, active low) empties the queue and the input register
// and sets the lexer idle at offset 0, line 1.
// When the receiver stalls, the queue holds its tokens and the input
// register holds one more byte; only then is o_ready taken low.
module script_token_lexer
    import stl_pkg::*;
#(
    parameter int MAX_TEXT_LEN = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic [62:0] o_int_value,
    output logic        o_bool_value,
    output logic [1:0]  o_error_code,
    output logic        o_last_of_run
);

    localparam logic [15:0] POS_MAX = (MAX_TEXT_LEN - 1 > 65535) ? 16'hFFFF
                                                                 : 16'(MAX_TEXT_LEN - 1);

    typedef struct packed {
        logic       emit;
        logic       drop;
        t_tok       tok;
    } t_fin;

    // Input register.
    logic        r_in_v;
    logic [7:0]  r_ch;
    logic        r_end;

    // Lexer state.
    t_mode       r_mode, n_mode;
    logic [7:0]  r_pend, n_pend;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_line, n_line;
    logic [15:0] r_so, n_so;
    logic [62:0] r_acc, n_acc;
    logic        r_dot, n_dot;
    logic [12:0] r_cand, n_cand;
    logic [3:0]  r_ilen, n_ilen;

    // Result queue.
    t_tok        r_q [3];
    logic [1:0]  r_qn;
    logic [1:0]  r_qi;

    t_tok        n_res [3];
    logic [1:0]  n_cnt;
    logic        proc;
    logic        out_xfer;

    function automatic t_tok mk(input logic [5:0] kind, input logic [15:0] ln,
                                input logic [15:0] st, input logic [15:0] len,
                                input logic [62:0] iv, input logic bv,
                                input logic [1:0] er);
        t_tok t;
        begin
            t.kind = kind; t.line = ln; t.start = st; t.length = len;
            t.ival = iv; t.bval = bv; t.err = er; t.last = 1'b0;
            mk = t;
        end
    endfunction

    // Finishes the pending token; its last byte lies just before offset p.
    function automatic t_fin finish(input t_mode m, input logic [7:0] pc,
                                    input logic [15:0] so, input logic [62:0] acc,
                                    input logic dot, input logic [12:0] cand,
                                    input logic [3:0] il, input logic [15:0] p,
                                    input logic [15:0] ln);
        t_fin       f;
        logic [5:0] kind;
        logic       bv;
        begin
            f.emit = 1'b0;
            f.drop = 1'b0;
            f.tok  = mk(K_EOS, ln, so, p - so, '0, 1'b0, E_NONE);
            kind   = K_IDENT;
            bv     = 1'b0;
            case (m)
                M_OP: begin
                    f.emit = 1'b1;
                    f.tok.length = 16'd1;
                    case (pc)
                        "+": f.tok.kind = K_PLUS;
                        "-": f.tok.kind = K_MINUS;
                        "*": f.tok.kind = K_MUL;
                        "/": f.tok.kind = K_DIV;
                        "!": f.tok.kind = K_NOT;
                        "=": f.tok.kind = K_EQUAL;
                        "<": f.tok.kind = K_LESS;
                        ">": f.tok.kind = K_GREATER;
                        "%": f.tok.kind = K_MODULO;
                        default: begin
                            f.tok.err = E_LONE_OP;
                            f.drop    = 1'b1;
                        end
                    endcase
                end
                M_NUMBER: begin
                    f.emit = 1'b1;
                    if (dot) begin
                        f.tok.kind = K_FLOAT;
                    end else begin
                        f.tok.kind = K_INT;
                        f.tok.ival = acc;
                    end
                end
                M_IDENT: begin
                    for (int k = 0; k < NKW; k++) begin
                        if (cand[k] && KW_LEN[k] == il) begin
                            kind = KW_KIND[k];
                            bv   = (k == KW_TRUE);
                        end
                    end
                    f.emit = 1'b1;
                    f.tok.kind = kind;
                    f.tok.bval = bv;
                end
                M_STRING: begin
                    f.emit = 1'b1;
                    f.drop = 1'b1;
                    f.tok.length = 16'd1;
                    f.tok.err = E_OPEN_STR;
                end
                default: ;
            endcase
            finish = f;
        end
    endfunction

    // Queue handshake.
    assign o_valid  = (r_qi != r_qn);
    assign out_xfer = o_valid && i_ready;
    assign proc     = r_in_v && (!o_valid || (out_xfer && (r_qi + 2'd1 == r_qn)));
    assign o_ready  = !r_in_v || proc;

    // One lexer step on the registered byte.
    always_comb begin
        logic [7:0]  b;
        logic [15:0] p;
        logic        do_idle;
        logic        do_fin;
        logic [5:0]  k2;
        logic [66:0] prod;
        t_fin        f;
        b = r_ch;
        p = r_pos;
        do_idle = 1'b0;
        do_fin  = 1'b0;
        k2      = K_EOS;
        prod    = '0;
        f       = '0;
        n_mode = r_mode; n_pend = r_pend; n_pos = r_pos; n_line = r_line;
        n_so = r_so; n_acc = r_acc; n_dot = r_dot; n_cand = r_cand; n_ilen = r_ilen;
        n_cnt = 2'd0;
        for (int i = 0; i < 3; i++) n_res[i] = '0;

        if (b != 8'd0) begin
            // Byte in a running token.
            case (n_mode)
                M_OP: begin
                    if (b == "=") begin
                        case (n_pend)
                            "+": k2 = K_PLUS_EQUAL;
                            "-": k2 = K_MINUS_EQUAL;
                            "*": k2 = K_MUL_EQUAL;
                            "/": k2 = K_DIV_EQUAL;
                            "!": k2 = K_NOT_EQUAL;
                            "=": k2 = K_DOUBLE_EQUAL;
                            "<": k2 = K_LESS_EQUAL;
                            ">": k2 = K_GREATER_EQUAL;
                            "%": k2 = K_MODULO_EQUAL;
                            default: k2 = K_EOS;
                        endcase
                    end else if (n_pend == "-" && b == ">") begin
                        k2 = K_ARROW;
                    end else if (n_pend == "&" && b == "&") begin
                        k2 = K_AND;
                    end else if (n_pend == "|" && b == "|") begin
                        k2 = K_OR;
                    end
                    if (k2 != K_EOS) begin
                        n_res[n_cnt] = mk(k2, n_line, n_so, 16'd2, '0, 1'b0, E_NONE);
                        n_cnt = n_cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else if (n_pend == "/" && b == "/") begin
                        n_mode = M_COMMENT;
                    end else begin
                        do_fin = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (b == 8'h0A) begin
                        n_mode = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (b >= "0" && b <= "9") begin
                        if (!n_dot) begin
                            prod = {n_acc, 3'b000} + {2'b00, n_acc, 1'b0}
                                 + {59'd0, b - "0"};
                            n_acc = (prod > {4'd0, INT_SAT}) ? INT_SAT : prod[62:0];
                        end
                    end else if (b == "." && !n_dot) begin
                        n_dot = 1'b1;
                    end else begin
                        do_fin = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (b == "_" || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
                        for (int k = 0; k < NKW; k++) begin
                            if (kw_char(k, n_ilen) != b) n_cand[k] = 1'b0;
                        end
                        if (n_ilen != 4'd15) n_ilen = n_ilen + 4'd1;
                    end else begin
                        do_fin = 1'b1;
                    end
                end
                M_STRING: begin
                    if (b == "\"") begin
                        n_res[n_cnt] = mk(K_STR, n_line,
                                          (n_so != 16'hFFFF) ? n_so + 16'd1 : n_so,
                                          (p > n_so) ? p - n_so - 16'd1 : 16'd0,
                                          '0, 1'b0, E_NONE);
                        n_cnt = n_cnt + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_DROP: ;
                default: do_idle = 1'b1;
            endcase

            if (do_fin) begin
                f = finish(n_mode, n_pend, n_so, n_acc, n_dot, n_cand, n_ilen, p, n_line);
                if (f.emit) begin
                    n_res[n_cnt] = f.tok;
                    n_cnt = n_cnt + 2'd1;
                end
                n_mode  = f.drop ? M_DROP : M_IDLE;
                do_idle = !f.drop;
            end

            // Byte between tokens.
            if (do_idle) begin
                case (b)
                    8'h0A: if (n_line != 16'hFFFF) n_line = n_line + 16'd1;
                    " ", 8'h0D, 8'h09: ;
                    "+", "-", "*", "/", "!", "=", "<", ">", "%", "&", "|": begin
                        n_mode = M_OP; n_pend = b; n_so = p;
                    end
                    "(", ")", "{", "}", ";", ":", ",": begin
                        case (b)
                            "(": k2 = K_OPEN_PAREN;
                            ")": k2 = K_CLOSE_PAREN;
                            "{": k2 = K_OPEN_BRACE;
                            "}": k2 = K_CLOSE_BRACE;
                            ";": k2 = K_SEMICOLON;
                            ":": k2 = K_COLON;
                            default: k2 = K_COMMA;
                        endcase
                        if (n_cnt != 2'd3) begin
                            n_res[n_cnt] = mk(k2, n_line, p, 16'd1, '0, 1'b0, E_NONE);
                            n_cnt = n_cnt + 2'd1;
                        end
                    end
                    "\"": begin
                        n_mode = M_STRING; n_so = p;
                    end
                    default: begin
                        if (b >= "0" && b <= "9") begin
                            n_mode = M_NUMBER; n_so = p; n_dot = 1'b0;
                            n_acc = {55'd0, b - "0"};
                        end else if (b == "_" || (b >= "a" && b <= "z")
                                     || (b >= "A" && b <= "Z")) begin
                            n_mode = M_IDENT; n_so = p; n_ilen = 4'd1;
                            for (int k = 0; k < NKW; k++) begin
                                n_cand[k] = (kw_char(k, 4'd0) == b);
                            end
                        end else begin
                            if (n_cnt != 2'd3) begin
                                n_res[n_cnt] = mk(K_EOS, n_line, p, 16'd1, '0, 1'b0,
                                                  E_BAD_CHAR);
                                n_cnt = n_cnt + 2'd1;
                            end
                            n_mode = M_DROP;
                        end
                    end
                endcase
            end

            if (p < POS_MAX) p = p + 16'd1;
            n_pos = p;
        end

        // End of text.
        if (r_end || b == 8'd0) begin
            if (n_mode != M_DROP) begin
                f = finish(n_mode, n_pend, n_so, n_acc, n_dot, n_cand, n_ilen, p, n_line);
                if (f.emit && n_cnt != 2'd3) begin
                    n_res[n_cnt] = f.tok;
                    n_cnt = n_cnt + 2'd1;
                end
                if (!f.drop && n_cnt != 2'd3) begin
                    n_res[n_cnt] = mk(K_EOS, n_line, p, 16'd0, '0, 1'b0, E_NONE);
                    n_cnt = n_cnt + 2'd1;
                end
            end
            n_mode = M_IDLE; n_pend = 8'd0; n_pos = 16'd0; n_line = 16'd1;
            n_so = 16'd0; n_acc = '0; n_dot = 1'b0; n_cand = '1; n_ilen = 4'd0;
        end

        if (n_cnt != 2'd0) n_res[n_cnt - 2'd1].last = 1'b1;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_qn   <= 2'd0;
            r_qi   <= 2'd0;
            r_mode <= M_IDLE;
            r_pend <= 8'd0;
            r_pos  <= 16'd0;
            r_line <= 16'd1;
            r_so   <= 16'd0;
            r_acc  <= '0;
            r_dot  <= 1'b0;
            r_cand <= '1;
            r_ilen <= 4'd0;
        end else begin
            if (o_ready) r_in_v <= i_valid;
            if (proc) begin
                r_qn   <= n_cnt;
                r_qi   <= 2'd0;
                r_mode <= n_mode;
                r_pend <= n_pend;
                r_pos  <= n_pos;
                r_line <= n_line;
                r_so   <= n_so;
                r_acc  <= n_acc;
                r_dot  <= n_dot;
                r_cand <= n_cand;
                r_ilen <= n_ilen;
            end else if (out_xfer) begin
                r_qi <= r_qi + 2'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch  <= i_ch;
            r_end <= i_end_of_input;
        end
        if (proc) begin
            for (int i = 0; i < 3; i++) r_q[i] <= n_res[i];
        end
    end

    // Output fields from the head of the queue.
    always_comb begin
        t_tok h;
        h = r_q[r_qi];
        o_token_kind   = h.kind;
        o_token_line   = h.line;
        o_token_start  = h.start;
        o_token_length = h.length;
        o_int_value    = h.ival;
        o_bool_value   = h.bval;
        o_error_code   = h.err;
        o_last_of_run  = h.last;
    end

    // The read index never passes the fill count.
    a_qi_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qi <= r_qn) else $error("queue read index past fill count");

    // Only the final queued token of a byte carries the last flag.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_run == (r_qi + 2'd1 == r_qn)))
        else $error("last flag misplaced");

    // The line count is never zero.
    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != 16'd0) else $error("line count is zero");

    // A byte is lexed only once the queue is empty or its last token transfers.
    a_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |-> (!o_valid || (i_ready && r_qi + 2'd1 == r_qn)))
        else $error("lexer step overwrote queued tokens");

endmodule

// File: test/stl_checker.sv
// Scoreboard for the script token lexer: predicts the tokens of each byte transfer
// and compares them with the output transfers. Depends on stl_pkg.
module stl_checker
    import stl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_input,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [5:0]  i_token_kind,
    input  logic [15:0] i_token_line,
    input  logic [15:0] i_token_start,
    input  logic [15:0] i_token_length,
    input  logic [62:0] i_int_value,
    input  logic        i_bool_value,
    input  logic [1:0]  i_error_code,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int POS_LIMIT = 65535;
    localparam logic [63:0] SAT64 = {1'b0, INT_SAT};

    // Keyword spellings in table order; kinds come from the package.
    string kw_word [NKW] = '{"if", "else", "while", "fn", "let", "const", "break",
                             "continue", "return", "true", "false", "null", "for"};

    t_tok        tok_q [$];
    t_mode       mode;
    logic [7:0]  held_op;
    int          cur_pos;
    int          cur_line;
    int          tok_start;
    logic [63:0] num_acc;
    logic        num_dot;
    logic [12:0] kw_live;
    int          word_len;
    int          step_toks;

    task automatic restart_text();
        mode      = M_IDLE;
        held_op   = 8'd0;
        cur_pos   = 0;
        cur_line  = 1;
        tok_start = 0;
        num_acc   = 64'd0;
        num_dot   = 1'b0;
        kw_live   = '1;
        word_len  = 0;
    endtask

    task automatic push_tok(input logic [5:0] kind, input int start, input int len,
                            input logic [63:0] ival, input logic bval,
                            input logic [1:0] err);
        t_tok t;
        if (step_toks >= 3) return;
        t.kind   = kind;
        t.line   = cur_line[15:0];
        t.start  = start[15:0];
        t.length = len[15:0];
        t.ival   = ival[62:0];
        t.bval   = bval;
        t.err    = err;
        t.last   = 1'b0;
        tok_q.push_back(t);
        step_toks++;
    endtask

    task automatic raise_error(input int at, input logic [1:0] code);
        push_tok(K_EOS, at, 1, 64'd0, 1'b0, code);
        mode = M_DROP;
    endtask

    function automatic bit is_alpha(input logic [7:0] b);
        return b == "_" || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // Narrow the keyword candidates with the next letter of a word.
    task automatic narrow_keywords(input logic [7:0] b);
        for (int k = 0; k < NKW; k++) begin
            if (kw_live[k] && (word_len >= kw_word[k].len() || kw_word[k][word_len] != b))
                kw_live[k] = 1'b0;
        end
        if (word_len < 15) word_len++;
    endtask

    task automatic add_digit(input logic [7:0] b);
        logic [63:0] d;
        d = {56'd0, b - 8'd48};
        if (num_acc > (SAT64 - d) / 10) num_acc = SAT64;
        else num_acc = num_acc * 10 + d;
    endtask

    // Close the token held open; its last byte sits just before offset p.
    task automatic close_token(input int p);
        int          len;
        logic [5:0]  kind;
        logic        bval;
        len = p - tok_start;
        case (mode)
            M_OP: begin
                case (held_op)
                    "+": push_tok(K_PLUS, tok_start, 1, 0, 0, E_NONE);
                    "-": push_tok(K_MINUS, tok_start, 1, 0, 0, E_NONE);
                    "*": push_tok(K_MUL, tok_start, 1, 0, 0, E_NONE);
                    "/": push_tok(K_DIV, tok_start, 1, 0, 0, E_NONE);
                    "!": push_tok(K_NOT, tok_start, 1, 0, 0, E_NONE);
                    "=": push_tok(K_EQUAL, tok_start, 1, 0, 0, E_NONE);
                    "<": push_tok(K_LESS, tok_start, 1, 0, 0, E_NONE);
                    ">": push_tok(K_GREATER, tok_start, 1, 0, 0, E_NONE);
                    "%": push_tok(K_MODULO, tok_start, 1, 0, 0, E_NONE);
                    default: begin
                        raise_error(tok_start, E_LONE_OP);
                        return;
                    end
                endcase
            end
            M_NUMBER: begin
                if (num_dot) push_tok(K_FLOAT, tok_start, len, 0, 0, E_NONE);
                else push_tok(K_INT, tok_start, len, num_acc, 0, E_NONE);
            end
            M_IDENT: begin
                kind = K_IDENT;
                bval = 1'b0;
                for (int k = 0; k < NKW; k++) begin
                    if (kw_live[k] && kw_word[k].len() == word_len) begin
                        kind = KW_KIND[k];
                        bval = (k == KW_TRUE);
                    end
                end
                push_tok(kind, tok_start, len, 0, bval, E_NONE);
            end
            M_STRING: begin
                raise_error(tok_start, E_OPEN_STR);
                return;
            end
            default: ;
        endcase
        mode = M_IDLE;
    endtask

    task automatic lex_idle(input logic [7:0] b, input int p);
        case (b)
            "\n": begin
                if (cur_line < 65535) cur_line++;
                return;
            end
            " ", "\r", "\t": return;
            "+", "-", "*", "/", "!", "=", "<", ">", "%", "&", "|": begin
                mode = M_OP;
                held_op = b;
                tok_start = p;
                return;
            end
            "(": begin push_tok(K_OPEN_PAREN, p, 1, 0, 0, E_NONE); return; end
            ")": begin push_tok(K_CLOSE_PAREN, p, 1, 0, 0, E_NONE); return; end
            "{": begin push_tok(K_OPEN_BRACE, p, 1, 0, 0, E_NONE); return; end
            "}": begin push_tok(K_CLOSE_BRACE, p, 1, 0, 0, E_NONE); return; end
            ";": begin push_tok(K_SEMICOLON, p, 1, 0, 0, E_NONE); return; end
            ":": begin push_tok(K_COLON, p, 1, 0, 0, E_NONE); return; end
            ",": begin push_tok(K_COMMA, p, 1, 0, 0, E_NONE); return; end
            "\"": begin
                mode = M_STRING;
                tok_start = p;
                return;
            end
            default: ;
        endcase
        if (is_num(b)) begin
            mode = M_NUMBER;
            tok_start = p;
            num_dot = 1'b0;
            num_acc = 64'd0;
            add_digit(b);
        end else if (is_alpha(b)) begin
            mode = M_IDENT;
            tok_start = p;
            kw_live = '1;
            word_len = 0;
            narrow_keywords(b);
        end else begin
            raise_error(p, E_BAD_CHAR);
        end
    endtask

    // Second byte of a possible two-character operator.
    task automatic lex_op(input logic [7:0] b, input int p);
        logic [5:0] kind;
        kind = K_EOS;
        if (b == "=") begin
            case (held_op)
                "+": kind = K_PLUS_EQUAL;
                "-": kind = K_MINUS_EQUAL;
                "*": kind = K_MUL_EQUAL;
                "/": kind = K_DIV_EQUAL;
                "!": kind = K_NOT_EQUAL;
                "=": kind = K_DOUBLE_EQUAL;
                "<": kind = K_LESS_EQUAL;
                ">": kind = K_GREATER_EQUAL;
                "%": kind = K_MODULO_EQUAL;
                default: ;
            endcase
        end else if (held_op == "-" && b == ">") kind = K_ARROW;
        else if (held_op == "&" && b == "&") kind = K_AND;
        else if (held_op == "|" && b == "|") kind = K_OR;
        else if (held_op == "/" && b == "/") begin
            mode = M_COMMENT;
            return;
        end
        if (kind != K_EOS) begin
            push_tok(kind, tok_start, 2, 0, 0, E_NONE);
            mode = M_IDLE;
            return;
        end
        close_token(p);
        if (mode == M_IDLE) lex_idle(b, p);
    endtask

    task automatic lex_byte(input logic [7:0] b, input int p);
        case (mode)
            M_OP: lex_op(b, p);
            M_COMMENT: begin
                if (b == "\n") begin
                    mode = M_IDLE;
                    lex_idle(b, p);
                end
            end
            M_NUMBER: begin
                if (is_num(b)) begin
                    if (!num_dot) add_digit(b);
                end else if (b == "." && !num_dot) begin
                    num_dot = 1'b1;
                end else begin
                    close_token(p);
                    lex_idle(b, p);
                end
            end
            M_IDENT: begin
                if (is_alpha(b)) narrow_keywords(b);
                else begin
                    close_token(p);
                    lex_idle(b, p);
                end
            end
            M_STRING: begin
                if (b == "\"") begin
                    push_tok(K_STR, (tok_start < 65535) ? tok_start + 1 : 65535,
                             (p > tok_start) ? p - tok_start - 1 : 0, 0, 0, E_NONE);
                    mode = M_IDLE;
                end
            end
            M_DROP: ;
            default: begin
                mode = M_IDLE;
                lex_idle(b, p);
            end
        endcase
    endtask

    // Predict all tokens caused by one byte transfer.
    task automatic predict_byte(input logic [7:0] b, input logic eoi);
        int p;
        p = cur_pos;
        step_toks = 0;
        if (b != 8'd0) begin
            lex_byte(b, p);
            if (p < POS_LIMIT) p++;
            cur_pos = p;
        end
        if (eoi || b == 8'd0) begin
            if (mode != M_DROP) begin
                close_token(p);
                if (mode != M_DROP) push_tok(K_EOS, p, 0, 0, 0, E_NONE);
            end
            restart_text();
        end
        if (step_toks > 0) tok_q[$].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        restart_text();
    end

    // Inputs are predicted before outputs are compared; a byte never shows a
    // token at its own transfer edge.
    always @(posedge i_clk) begin
        t_tok e;
        if (!i_rst_n) begin
            restart_text();
            tok_q.delete();
        end else begin
            if (i_valid && i_in_ready) predict_byte(i_ch, i_end_of_input);
            if (i_out_valid && i_out_ready) begin
                if (tok_q.size() == 0) begin
                    $error("unexpected token transfer, kind %0d", i_token_kind);
                    o_fail_count++;
                end else begin
                    e = tok_q.pop_front();
                    check_field("token_kind", e.kind, i_token_kind);
                    check_field("token_line", e.line, i_token_line);
                    check_field("token_start", e.start, i_token_start);
                    check_field("token_length", e.length, i_token_length);
                    check_field("int_value", e.ival, i_int_value);
                    check_field("bool_value", e.bval, i_bool_value);
                    check_field("error_code", e.err, i_error_code);
                    check_field("last_of_run", e.last, i_last_of_run);
                end
            end
        end
        o_pending = tok_q.size();
    end

endmodule

// File: test/tb_script_token_lexer.sv
// Testbench top for the script token lexer: drives byte texts under varying idle
// and stall patterns and gives the verdict. Depends on stl_pkg and stl_checker.
module tb_script_token_lexer;
    import stl_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_ch;
    logic        i_end_of_input;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_token_kind;
    logic [15:0] o_token_line;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic [62:0] o_int_value;
    logic        o_bool_value;
    logic [1:0]  o_error_code;
    logic        o_last_of_run;

    int          fail_count;
    int          pending;
    int          cycles;
    int          tx_idle_pct;
    int          rx_stall_pct;
    logic [7:0]  text_q [$];

    // Pieces of well-formed source text.
    string frags [] = '{"if", "else", "while", "fn", "let", "const", "break", "continue",
        "return", "true", "false", "null", "for", "foo", "_Bar", "iff", "els", "x", "ZZ",
        "0", "42", "9223372036854775807", "99999999999999999999", "3.14", "1.2.3", "7.",
        "+", "+=", "-", "-=", "->", "*", "*=", "/", "/=", "!", "!=", "&&", "||", "(",
        ")", "{", "}", "=", "==", ";", ":", ",", "<", "<=", ">", ">=", "%", "%=",
        "\"hi\"", "\"a\nb\"", "\"\"", "// note ; x\n", "\n", " ", "\t", "\r"};
    string breaks [] = '{"&", "|", "\"open", "@", "#", "$", "."};

    script_token_lexer u_dut (.*);

    stl_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_in_ready     (o_ready),
        .i_ch           (i_ch),
        .i_end_of_input (i_end_of_input),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_token_kind   (o_token_kind),
        .i_token_line   (o_token_line),
        .i_token_start  (o_token_start),
        .i_token_length (o_token_length),
        .i_int_value    (o_int_value),
        .i_bool_value   (o_bool_value),
        .i_error_code   (o_error_code),
        .i_last_of_run  (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_script_token_lexer failed");
            $finish;
        end
    end

    // Receiver stalls at the current rate.
    always @(negedge i_clk) begin
        i_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_ch = b;
        i_end_of_input = eoi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // Send the queued text; it ends with the flag or with a zero byte.
    task automatic send_text(input bit zero_end);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], !zero_end && i == text_q.size() - 1);
        if (zero_end) send_byte(8'd0, 1'(($urandom_range(1))));
        text_q.delete();
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly token sequences with random spacing, some broken or pure noise.
    task automatic make_random_text();
        int n;
        int pick;
        n = $urandom_range(12, 1);
        pick = $urandom_range(99);
        for (int i = 0; i < n; i++) begin
            if (pick < 8) text_q.push_back(8'($urandom_range(255, 1)));
            else begin
                if ($urandom_range(99) < 6) add_str(breaks[$urandom_range(breaks.size() - 1)]);
                else add_str(frags[$urandom_range(frags.size() - 1)]);
                case ($urandom_range(3))
                    0: add_str(" ");
                    1: add_str("\n");
                    default: ;
                endcase
            end
        end
    endtask

    initial begin
        int sent;
        cycles = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        i_valid = 1'b0;
        i_ch = 8'd0;
        i_end_of_input = 1'b0;
        i_ready = 1'b1;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed texts: operators, literals, saturation, errors, both endings.
        add_str("a+=1.5;");
        send_text(1'b0);
        add_str("\"s\"->true");
        send_text(1'b1);
        add_str("99999999999999999999");
        send_text(1'b0);
        add_str("&y");
        send_text(1'b0);
        add_str("\"x");
        send_text(1'b1);
        send_byte(8'hFF, 1'b1);

        // A text spread over several lines.
        repeat (3) text_q.push_back("\n");
        add_str("if 12");
        send_text(1'b0);
        wait_drained();

        // Random texts over the idle and stall phases.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            sent = 0;
            while (sent < 100) begin
                make_random_text();
                sent += text_q.size() + 1;
                send_text($urandom_range(3) == 0);
            end
            // After the sender idle phase, hold off the sender until every token has arrived.
            if (ph == 1) wait_drained();
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) $display("tb_script_token_lexer passed");
        else $display("tb_script_token_lexer failed");
        $finish;
    end

endmodule
